@@ hdl/bud_pkg.sv @@
// ============================================================================
// bud_pkg
// Shared constants and types for the buddy allocator.
// ============================================================================
`default_nettype none
package bud_pkg;
  localparam int TopLevel = 11;
  localparam int NodeW = TopLevel + 1;
  localparam int LvlW = 4;
  localparam int AddrW = 12;
  localparam int SizeW = 13;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_UNUSED = 2'd0;
  localparam kind_t KIND_FREE = 2'd1;
  localparam kind_t KIND_ALLOC = 2'd2;
  localparam kind_t KIND_SPLIT = 2'd3;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BADADDR = 2'd2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE = 1'b1;

  typedef struct packed {
    kind_t kind;
    logic [LvlW-1:0] lfb;
  } node_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_AREAD, S_ADESC, S_ASPLIT, S_FREAD, S_FDESC,
    S_MREAD, S_MERGE, S_RREAD, S_REFRESH, S_OUT
  } state_t;
endpackage
`default_nettype wire

@@ hdl/bud_ram.sv @@
// ============================================================================
// bud_ram
// Tree node store, one write and two registered reads per cycle.
// ============================================================================
`default_nettype none
module bud_ram #(
  parameter int AW = 12,
  parameter int DW = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr_a,
  input  wire logic [AW-1:0] raddr_b,
  output logic      [DW-1:0] rdata_a,
  output logic      [DW-1:0] rdata_b
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule
`default_nettype wire

@@ hdl/buddy_allocator_top.sv @@
// ============================================================================
// buddy_allocator_top
// Buddy allocator over a 4096-byte pool with a tree of block nodes in RAM.
// ============================================================================
// After reset the block sweeps the node RAM once with stall high.
// Each request then walks the tree one node at a time through the node RAM,
// which has registered reads and a single write port. Allocate descends level
// by level, splits level by level and then refreshes the path to the root
// (read children, read node, write back). Free descends level by level, merges
// with free buddies level by level and refreshes likewise. A request that fails
// at the root returns its result without walking further. One request is
// handled at a time; the next is taken once the result register is empty or
// read in the same cycle.
`default_nettype none
module buddy_allocator_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       command,
  input  wire logic [bud_pkg::SizeW-1:0]  request_size,
  input  wire logic [bud_pkg::AddrW-1:0]  block_address,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [1:0]                      status,
  output logic [bud_pkg::AddrW-1:0]       granted_address,
  output logic [bud_pkg::LvlW-1:0]        granted_level
);
  import bud_pkg::*;

  state_t state, state_next;
  logic [NodeW-1:0] n, n_next;
  logic [LvlW-1:0] lvl, lvl_next, need, need_next;
  logic [AddrW-1:0] start, start_next, addr, addr_next;
  logic [SizeW-1:0] size, size_next;
  logic [AddrW-1:0] grant_addr, grant_addr_next;
  logic [LvlW-1:0] grant_lvl, grant_lvl_next;

  logic we;
  logic [NodeW-1:0] waddr, ra, rb;
  node_t wdata, da, db;

  bud_ram #(.AW(NodeW), .DW($bits(node_t))) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr_a(ra), .raddr_b(rb), .rdata_a(da), .rdata_b(db)
  );

  logic [1:0] res_st_next;
  logic [AddrW-1:0] res_addr_next;
  logic [LvlW-1:0] res_lvl_next;
  logic res_load;

  logic [LvlW-1:0] need_calc;
  logic [SizeW:0] half;
  logic [LvlW-1:0] mx;

  always_comb begin
    need_calc = LvlW'(TopLevel);
    for (int i = TopLevel - 1; i >= 0; i--) begin
      if ((SizeW+1)'(2) << i >= {1'b0, request_size}) begin
        need_calc = LvlW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      n <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      n <= n_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lvl <= lvl_next;
    need <= need_next;
    start <= start_next;
    addr <= addr_next;
    size <= size_next;
    grant_addr <= grant_addr_next;
    grant_lvl <= grant_lvl_next;
    if (res_load) begin
      status <= res_st_next;
      granted_address <= res_addr_next;
      granted_level <= res_lvl_next;
    end
  end

  always_comb begin
    state_next = state;
    n_next = n;
    lvl_next = lvl;
    need_next = need;
    start_next = start;
    addr_next = addr;
    size_next = size;
    grant_addr_next = grant_addr;
    grant_lvl_next = grant_lvl;
    we = 1'b0;
    waddr = n;
    wdata = '{kind: KIND_UNUSED, lfb: '0};
    ra = n;
    rb = n ^ NodeW'(1);
    res_st_next = ST_DONE;
    res_addr_next = '0;
    res_lvl_next = '0;
    res_load = 1'b0;
    in_stall = 1'b1;
    half = (SizeW+1)'(1) << lvl;
    mx = (da.lfb > db.lfb) ? da.lfb : db.lfb;
    case (state)
      S_CLEAR: begin
        we = 1'b1;
        waddr = n;
        if (n == NodeW'(1)) begin
          wdata = '{kind: KIND_FREE, lfb: LvlW'(TopLevel + 1)};
        end
        n_next = n + NodeW'(1);
        if (n == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = out_valid && out_stall;
        n_next = NodeW'(1);
        ra = NodeW'(1);
        lvl_next = LvlW'(TopLevel);
        start_next = '0;
        need_next = need_calc;
        addr_next = block_address;
        size_next = request_size;
        grant_addr_next = '0;
        grant_lvl_next = '0;
        if (in_valid && !in_stall) begin
          state_next = (command == CMD_ALLOC) ? S_AREAD : S_FREAD;
        end
      end
      S_AREAD: begin
        // da holds node n; fetch children
        ra = {n[NodeW-2:0], 1'b0};
        rb = {n[NodeW-2:0], 1'b1};
        if (size > SizeW'(2 << TopLevel) || (n == NodeW'(1) && da.lfb < need + 1'b1)) begin
          res_st_next = ST_NOSPACE;
          res_load = 1'b1;
          state_next = S_IDLE;
        end else if (da.kind == KIND_FREE && lvl >= need) begin
          state_next = S_ASPLIT;
        end else if (da.kind != KIND_SPLIT || lvl == '0) begin
          res_st_next = ST_NOSPACE;
          res_load = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_ADESC;
        end
      end
      S_ADESC: begin
        if (da.lfb >= need + 1'b1) begin
          n_next = {n[NodeW-2:0], 1'b0};
        end else begin
          n_next = {n[NodeW-2:0], 1'b1};
          start_next = start + (AddrW'(1) << lvl);
        end
        lvl_next = lvl - 1'b1;
        ra = n_next;
        state_next = S_AREAD;
      end
      S_ASPLIT: begin
        we = 1'b1;
        if (lvl > '0 && half > {1'b0, size}) begin
          // mark node split; S_MERGE then writes the right child free and descends to the left
          waddr = n;
          wdata = '{kind: KIND_SPLIT, lfb: '0};
          state_next = S_MERGE;
          addr_next = '0;
        end else begin
          waddr = n;
          wdata = '{kind: KIND_ALLOC, lfb: '0};
          grant_addr_next = start;
          grant_lvl_next = lvl;
          state_next = S_RREAD;
        end
      end
      S_MERGE: begin
        if (addr == '0) begin
          // split continuation: write right child free, then split or allocate the left
          we = 1'b1;
          waddr = {n[NodeW-2:0], 1'b1};
          wdata = '{kind: KIND_FREE, lfb: lvl};
          n_next = {n[NodeW-2:0], 1'b0};
          lvl_next = lvl - 1'b1;
          state_next = S_ASPLIT;
        end else begin
          // free merge: da = node n, db = buddy
          if (n > NodeW'(1) && db.kind == KIND_FREE) begin
            we = 1'b1;
            waddr = n ^ NodeW'(1);
            wdata = '{kind: KIND_UNUSED, lfb: '0};
            state_next = S_MREAD;
          end else begin
            we = 1'b1;
            waddr = n;
            wdata = '{kind: KIND_FREE, lfb: '0};
            state_next = S_RREAD;
          end
        end
      end
      S_MREAD: begin
        we = 1'b1;
        waddr = n;
        wdata = '{kind: KIND_UNUSED, lfb: '0};
        n_next = n >> 1;
        lvl_next = lvl + 1'b1;
        ra = n_next;
        rb = n_next ^ NodeW'(1);
        state_next = S_MERGE;
      end
      S_FREAD: begin
        if (addr >= AddrW'(2 << TopLevel) && (2 << TopLevel) <= (1 << AddrW) - 1) begin
          res_st_next = ST_BADADDR;
          res_load = 1'b1;
          state_next = S_IDLE;
        end else if (da.kind == KIND_FREE || da.kind == KIND_ALLOC) begin
          if (start != addr) begin
            res_st_next = ST_BADADDR;
            res_load = 1'b1;
            state_next = S_IDLE;
          end else if (da.kind == KIND_FREE) begin
            res_load = 1'b1;
            state_next = S_IDLE;
          end else begin
            we = 1'b1;
            wdata = '{kind: KIND_FREE, lfb: '0};
            addr_next = '1;
            state_next = S_FDESC;
          end
        end else if (da.kind != KIND_SPLIT || lvl == '0) begin
          res_st_next = ST_BADADDR;
          res_load = 1'b1;
          state_next = S_IDLE;
        end else begin
          if (addr - start >= (AddrW'(1) << lvl)) begin
            start_next = start + (AddrW'(1) << lvl);
            n_next = {n[NodeW-2:0], 1'b1};
          end else begin
            n_next = {n[NodeW-2:0], 1'b0};
          end
          lvl_next = lvl - 1'b1;
          ra = n_next;
          state_next = S_FREAD;
        end
      end
      S_FDESC: begin
        ra = n;
        rb = n ^ NodeW'(1);
        state_next = S_MERGE;
      end
      S_RREAD: begin
        // read children for refresh; the node itself is read in S_OUT
        ra = {n[NodeW-2:0], 1'b0};
        rb = {n[NodeW-2:0], 1'b1};
        state_next = S_OUT;
      end
      S_OUT: begin
        ra = n;
        state_next = S_REFRESH;
        mx = (da.lfb > db.lfb) ? da.lfb : db.lfb;
        lvl_next = lvl;
        need_next = (lvl > '0) ? mx : '0;
      end
      S_REFRESH: begin
        we = 1'b1;
        waddr = n;
        wdata.kind = da.kind;
        if (da.kind == KIND_FREE) begin
          wdata.lfb = lvl + 1'b1;
        end else if (da.kind == KIND_SPLIT) begin
          wdata.lfb = need;
        end else begin
          wdata.lfb = '0;
        end
        if (n <= NodeW'(1)) begin
          res_load = 1'b1;
          res_st_next = ST_DONE;
          res_addr_next = grant_addr;
          res_lvl_next = grant_lvl;
          state_next = S_IDLE;
        end else begin
          n_next = n >> 1;
          lvl_next = lvl + 1'b1;
          state_next = S_RREAD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ hdl/bud_checker.sv @@
// ============================================================================
// bud_checker
// Port-level checks for the buddy allocator.
// ============================================================================
`default_nettype none
module bud_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] status,
  input wire logic [11:0] granted_address,
  input wire logic [3:0] granted_level
);
  import bud_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status))
    else $error("result dropped while stalled");
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_BADADDR)
    else $error("bad status");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_DONE |-> granted_address == '0 && granted_level == '0)
    else $error("fields not zero on failure");
endmodule

bind buddy_allocator_top bud_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .status(status), .granted_address(granted_address), .granted_level(granted_level)
);
`default_nettype wire

@@ dv/tb_buddy_allocator_top.sv @@
// ============================================================================
// tb_buddy_allocator_top
// Self-checking testbench for the buddy allocator.
// A tree model of the pool predicts status, granted address and level for
// each request. Stimulus is directed corner cases, then random allocate and
// free traffic that mostly frees live blocks, with random gaps and stalls.
// ============================================================================
module tb_buddy_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bud_pkg::*;

  localparam int PoolBytes = 1 << (TopLevel + 1);

  typedef struct {
    logic             cmd;
    logic [SizeW-1:0] size;
    logic [AddrW-1:0] addr;
  } req_t;

  typedef struct {
    logic [1:0]       st;
    logic [AddrW-1:0] addr;
    logic [LvlW-1:0]  lvl;
  } grant_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             command = CMD_ALLOC;
  logic [SizeW-1:0] request_size = '0;
  logic [AddrW-1:0] block_address = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       status;
  logic [AddrW-1:0] granted_address;
  logic [LvlW-1:0]  granted_level;

  kind_t          tree_kind [2][PoolBytes];
  logic [LvlW-1:0] tree_free_lvl [2][PoolBytes];

  req_t         pending_reqs[$];
  bit           pending_quiet[$];
  grant_t       expected_grants[$];
  logic [AddrW-1:0] live_blocks[$];
  int           gap_left = 0;
  bit           quiet = 1'b0;
  bit           gen_quiet = 1'b0;
  int           errors = 0;
  int           n_alloc = 0, n_free = 0, n_nospace = 0, n_badaddr = 0;

  buddy_allocator_top u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .request_size(request_size), .block_address(block_address),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .granted_address(granted_address), .granted_level(granted_level)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void pool_reset(int m);
    for (int i = 0; i < PoolBytes; i++) begin
      tree_kind[m][i] = KIND_UNUSED;
      tree_free_lvl[m][i] = '0;
    end
    tree_kind[m][1] = KIND_FREE;
    tree_free_lvl[m][1] = LvlW'(TopLevel + 1);
  endfunction

  function automatic void refresh_upward(int m, int n, int l);
    logic [LvlW-1:0] v, a, b;
    forever begin
      v = '0;
      if (tree_kind[m][n] == KIND_FREE) begin
        v = LvlW'(l + 1);
      end else if (tree_kind[m][n] == KIND_SPLIT && l > 0) begin
        a = tree_free_lvl[m][2*n];
        b = tree_free_lvl[m][2*n+1];
        v = a > b ? a : b;
      end
      tree_free_lvl[m][n] = v;
      if (n <= 1) return;
      n = n >> 1;
      l++;
    end
  endfunction

  function automatic void pool_step(int m, req_t r, output grant_t g);
    int need, l, n, start, sz;
    g = '{st: ST_DONE, addr: '0, lvl: '0};
    l = TopLevel;
    n = 1;
    start = 0;
    need = 0;
    sz = r.size;
    if (r.cmd == CMD_ALLOC) begin
      g.st = ST_NOSPACE;
      if (sz > PoolBytes) return;
      while (need < TopLevel && (1 << (need + 1)) < sz) need++;
      if (tree_free_lvl[m][1] < need + 1) return;
      forever begin
        if (tree_kind[m][n] == KIND_FREE && l >= need) break;
        if (tree_kind[m][n] != KIND_SPLIT || l == 0) return;
        if (tree_free_lvl[m][2*n] >= need + 1) begin
          n = 2 * n;
        end else begin
          start += 1 << l;
          n = 2 * n + 1;
        end
        l--;
      end
      while (l > 0 && (1 << l) > sz) begin
        tree_kind[m][n] = KIND_SPLIT;
        tree_kind[m][2*n] = KIND_FREE;
        tree_kind[m][2*n+1] = KIND_FREE;
        tree_free_lvl[m][2*n] = LvlW'(l);
        tree_free_lvl[m][2*n+1] = LvlW'(l);
        n = 2 * n;
        l--;
      end
      tree_kind[m][n] = KIND_ALLOC;
      refresh_upward(m, n, l);
      g = '{st: ST_DONE, addr: AddrW'(start), lvl: LvlW'(l)};
    end else begin
      g.st = ST_BADADDR;
      forever begin
        if (tree_kind[m][n] == KIND_FREE || tree_kind[m][n] == KIND_ALLOC) begin
          if (start != r.addr) return;
          break;
        end
        if (tree_kind[m][n] != KIND_SPLIT || l == 0) return;
        if (r.addr - start >= (1 << l)) begin
          start += 1 << l;
          n = 2 * n + 1;
        end else begin
          n = 2 * n;
        end
        l--;
      end
      tree_kind[m][n] = KIND_FREE;
      while (n > 1 && tree_kind[m][n^1] == KIND_FREE) begin
        tree_kind[m][n] = KIND_UNUSED;
        tree_kind[m][n^1] = KIND_UNUSED;
        tree_free_lvl[m][n] = '0;
        tree_free_lvl[m][n^1] = '0;
        n = n >> 1;
        l++;
        tree_kind[m][n] = KIND_FREE;
      end
      refresh_upward(m, n, l);
      g.st = ST_DONE;
    end
  endfunction

  function automatic void queue_req(logic cmd, int size, int addr);
    req_t   r;
    grant_t g;
    r = '{cmd: cmd, size: SizeW'(size), addr: AddrW'(addr)};
    pool_step(0, r, g);
    if (cmd == CMD_ALLOC && g.st == ST_DONE) live_blocks.push_back(g.addr);
    pending_reqs.push_back(r);
    pending_quiet.push_back(gen_quiet);
  endfunction

  function automatic int pick_gap(bit q);
    int r;
    r = $urandom_range(0, 99);
    if (q || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req_t r;
        bit   q;
        r = pending_reqs.pop_front();
        q = pending_quiet.pop_front();
        command <= r.cmd;
        request_size <= r.size;
        block_address <= r.addr;
        in_valid <= 1'b1;
        quiet <= q;
        gap_left <= pick_gap(q);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 25);
    end
  end

  always @(posedge clk) begin
    req_t   r;
    grant_t g, e;
    if (!rst && in_valid && !in_stall) begin
      r = '{cmd: command, size: request_size, addr: block_address};
      pool_step(1, r, g);
      expected_grants.push_back(g);
      if (r.cmd == CMD_ALLOC) n_alloc++;
      else n_free++;
      if (g.st == ST_NOSPACE) n_nospace++;
      if (g.st == ST_BADADDR) n_badaddr++;
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_grants.size() == 0) begin
        $error("unexpected result: status %0d", status);
        errors++;
      end else begin
        e = expected_grants.pop_front();
        if (status !== e.st) begin
          $error("status: expected %0d, got %0d", e.st, status);
          errors++;
        end
        if (granted_address !== e.addr) begin
          $error("granted_address: expected %0d, got %0d", e.addr, granted_address);
          errors++;
        end
        if (granted_level !== e.lvl) begin
          $error("granted_level: expected %0d, got %0d", e.lvl, granted_level);
          errors++;
        end
      end
    end
  end

  initial begin
    int idx, r;
    pool_reset(0);
    pool_reset(1);

    queue_req(CMD_FREE, 0, 0);
    queue_req(CMD_ALLOC, 4097, 0);
    queue_req(CMD_ALLOC, 8191, 4095);
    queue_req(CMD_ALLOC, 4096, 0);
    queue_req(CMD_ALLOC, 1, 0);
    queue_req(CMD_FREE, 0, 0);
    queue_req(CMD_FREE, 0, 4095);
    queue_req(CMD_ALLOC, 0, 0);
    queue_req(CMD_ALLOC, 1, 0);
    queue_req(CMD_ALLOC, 2, 0);
    queue_req(CMD_ALLOC, 3, 0);
    queue_req(CMD_ALLOC, 2048, 0);
    queue_req(CMD_ALLOC, 2049, 0);
    queue_req(CMD_FREE, 0, 1);
    queue_req(CMD_FREE, 0, 6);
    queue_req(CMD_FREE, 0, 2);
    queue_req(CMD_FREE, 0, 2);
    queue_req(CMD_FREE, 0, 2048);
    queue_req(CMD_FREE, 0, 0);
    queue_req(CMD_FREE, 0, 4);
    queue_req(CMD_FREE, 0, 8);
    queue_req(CMD_ALLOC, 4096, 0);
    queue_req(CMD_FREE, 0, 0);
    live_blocks.delete();

    for (int i = 0; i < 1950; i++) begin
      if (i % 250 == 0) gen_quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 50) begin
        if ($urandom_range(0, 9) < 7) queue_req(CMD_ALLOC, $urandom_range(0, 96), 0);
        else if ($urandom_range(0, 3) > 0) queue_req(CMD_ALLOC, $urandom_range(0, 4096), 0);
        else queue_req(CMD_ALLOC, $urandom_range(0, 8191), $urandom_range(0, 4095));
      end else if (r < 88 && live_blocks.size() > 0) begin
        idx = $urandom_range(0, live_blocks.size() - 1);
        queue_req(CMD_FREE, $urandom_range(0, 8191), live_blocks[idx]);
        if ($urandom_range(0, 19) != 0) live_blocks.delete(idx);
      end else begin
        queue_req(CMD_FREE, 0, $urandom_range(0, 4095));
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Covered %0d allocate and %0d free requests.", n_alloc, n_free);
    $display("No-space results: %0d, bad-address results: %0d.", n_nospace, n_badaddr);
    if (errors == 0 && expected_grants.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("Verification failed");
    $finish;
  end
endmodule
